// ===== rtl/gpqd_pkg.sv =====
`default_nettype none

package gpqd_pkg;

    // default number of controller ports held in the state memory
    localparam int PORTS_DEFAULT = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_ALT_MODE   = 2'd0;
    localparam logic [1:0] CFG_DELTA_TBL  = 2'd1;
    localparam logic [1:0] CFG_STEP_MULT  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // reset values of the configuration registers
    localparam logic        ALT_MODE_RST  = 1'b0;
    localparam logic [31:0] DELTA_TBL_RST = 32'd0;
    localparam logic [6:0]  STEP_MULT_RST = 7'd1;

    // pattern masks for the select and start combos
    localparam logic [6:0] COMBO_SEL_MASK   = 7'h03;
    localparam logic [6:0] COMBO_START_MASK = 7'h0C;

    localparam logic [7:0]  POS_MAX    = 8'd255;
    localparam logic [15:0] AXIS_BIAS  = 16'd32768;

    // one pin sample, 0 = low / pressed
    typedef struct packed {
        logic up;
        logic dn;
        logic lf;
        logic rt;
        logic tl;
        logic th;
        logic tr;
    } pins_t;

    // per-port state word kept in the state memory
    typedef struct packed {
        logic       drv;
        logic [1:0] quad;
        logic [6:0] pin;
        logic [7:0] pos;
    } port_st_t;

    localparam port_st_t PORT_ST_RST = '{drv: 1'b0, quad: 2'd3, pin: 7'd0, pos: 8'd128};

    // one result
    typedef struct packed {
        logic               updated;
        logic               driving;
        logic               pad_up;
        logic               pad_down;
        logic               pad_left;
        logic               pad_right;
        logic               button_a;
        logic               button_b;
        logic               button_select;
        logic               button_start;
        logic [7:0]         paddle_position;
        logic signed [15:0] axis_x;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/gpqd_step.sv =====
`default_nettype none

module gpqd_step (
    input  wire logic               alt_mode,
    input  wire logic [31:0]        delta_tbl,
    input  wire logic [6:0]         step_mult,
    input  wire gpqd_pkg::pins_t    pins,
    input  wire gpqd_pkg::port_st_t st_cur,
    output gpqd_pkg::port_st_t      st_next,
    output gpqd_pkg::res_t          res
);
    import gpqd_pkg::*;

    logic [1:0]        cur_code;
    logic [1:0]        prev_code;
    logic              second;
    logic              act_both_low;
    logic              drv_a;
    logic              quad_chg;
    logic [1:0]        delta;
    logic              act_step;
    logic              drv_b;
    logic              move;
    logic signed [8:0] offset;
    logic signed [9:0] pos_sum;
    logic [7:0]        pos_new;
    logic [6:0]        pat;
    logic              sel;
    logic              run;
    logic              upd;

    assign cur_code  = {pins.up, pins.dn};
    assign prev_code = st_cur.quad;
    assign second    = alt_mode ? pins.th : pins.tr;

    // driving mode entry: both quadrature lines low
    assign act_both_low = !alt_mode && !st_cur.drv && !pins.up && !pins.dn;
    assign drv_a        = st_cur.drv | act_both_low;

    // step lookup from the previous and current codes
    assign quad_chg = !alt_mode && (cur_code != prev_code);
    assign delta    = 2'(delta_tbl >> {prev_code, cur_code, 1'b0});

    // driving mode entry: nonzero step touching code 0
    assign act_step = quad_chg && !drv_a && (delta != 2'b00)
                      && ((cur_code == 2'b00) || (prev_code == 2'b00));
    assign drv_b    = drv_a | act_step;
    assign move     = quad_chg && drv_b && (delta != 2'b00);

    // step times multiplier, delta is one of -2, -1, 0, 1
    always_comb begin
        unique case (delta)
            2'b01:   offset = $signed({2'b00, step_mult});
            2'b11:   offset = -$signed({2'b00, step_mult});
            2'b10:   offset = -$signed({1'b0, step_mult, 1'b0});
            default: offset = '0;
        endcase
    end

    // saturating position update
    assign pos_sum = $signed({2'b00, st_cur.pos}) + $signed({offset[8], offset});
    always_comb begin
        if (!move) begin
            pos_new = st_cur.pos;
        end else if (pos_sum < 0) begin
            pos_new = '0;
        end else if (pos_sum > $signed({2'b00, POS_MAX})) begin
            pos_new = POS_MAX;
        end else begin
            pos_new = pos_sum[7:0];
        end
    end

    // pattern compare for the change flag
    assign pat = {1'b1, second, pins.tl, pins.rt, pins.lf, pins.dn, pins.up};
    assign sel = alt_mode && ((pat & COMBO_SEL_MASK) == '0);
    assign run = alt_mode && ((pat & COMBO_START_MASK) == '0);
    assign upd = (pat != st_cur.pin) || act_both_low || act_step;

    assign st_next.drv  = drv_b;
    assign st_next.quad = cur_code;
    assign st_next.pin  = upd ? pat : st_cur.pin;
    assign st_next.pos  = pos_new;

    // button mapping
    always_comb begin
        res                 = '0;
        res.updated         = upd;
        res.driving         = drv_b;
        res.paddle_position = pos_new;
        res.pad_up          = !pins.up;
        res.pad_down        = !pins.dn;
        res.pad_left        = !pins.lf;
        res.pad_right       = !pins.rt;
        if (drv_b) begin
            res.pad_up   = 1'b0;
            res.pad_down = 1'b0;
            res.button_a = !pins.tl;
            res.button_b = !second;
            res.axis_x   = $signed({pos_new, 8'h00} - AXIS_BIAS);
        end else if (alt_mode) begin
            res.button_a = !pins.th;
            res.button_b = !pins.tl;
            if (sel) begin
                res.pad_up        = 1'b0;
                res.pad_down      = 1'b0;
                res.button_select = 1'b1;
            end
            if (run) begin
                res.pad_left     = 1'b0;
                res.pad_right    = 1'b0;
                res.button_start = 1'b1;
            end
        end else begin
            res.button_a = !pins.tl;
            res.button_b = !pins.tr;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gamepad_paddle_quadrature_decoder_unit.sv =====
`default_nettype none

// Paddle / pad decoder for up to PORTS controller ports. Each request is one
// pin sample of one port and yields exactly one result. The per-port state
// (driving flag, last quadrature code, last reported pattern, position) lives
// in a synchronous memory read when the request is taken; the step logic
// updates it and writes it back, with a bypass of the last written entry
// so that back-to-back requests to the same port see fresh state. A request
// passes the request stage and the result register; a new request is taken
// every cycle unless a result is stalled. Ports at or beyond PORTS return an
// all-zero result and leave state untouched. Entries read as their reset
// values until first written, so no clearing pass is needed after reset.

module gamepad_paddle_quadrature_decoder_unit #(
    parameter int PORTS = gpqd_pkg::PORTS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_wr_en,
    input  wire logic [gpqd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gpqd_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_port,
    input  wire logic                            s_pin_up,
    input  wire logic                            s_pin_down,
    input  wire logic                            s_pin_left,
    input  wire logic                            s_pin_right,
    input  wire logic                            s_pin_tl,
    input  wire logic                            s_pin_th,
    input  wire logic                            s_pin_tr,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_updated,
    output logic                                 m_driving,
    output logic                                 m_pad_up,
    output logic                                 m_pad_down,
    output logic                                 m_pad_left,
    output logic                                 m_pad_right,
    output logic                                 m_button_a,
    output logic                                 m_button_b,
    output logic                                 m_button_select,
    output logic                                 m_button_start,
    output logic [7:0]                           m_paddle_position,
    output logic signed [15:0]                   m_axis_x
);
    import gpqd_pkg::*;

    localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // configuration registers
    logic        alt_mode_reg;
    logic [31:0] delta_tbl_reg;
    logic [6:0]  step_mult_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_mode_reg  <= ALT_MODE_RST;
            delta_tbl_reg <= DELTA_TBL_RST;
            step_mult_reg <= STEP_MULT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ALT_MODE:  alt_mode_reg  <= cfg_wdata[0];
                CFG_DELTA_TBL: delta_tbl_reg <= cfg_wdata[31:0];
                CFG_STEP_MULT: step_mult_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    logic             s_fire;
    logic             s_in_range;
    logic [IDX_W-1:0] rd_addr;

    logic             s1_valid_reg;
    logic             s1_in_range_reg;
    logic [IDX_W-1:0] s1_addr_reg;
    pins_t            s1_pins_reg;
    logic             s1_adv;

    port_st_t         state_mem [PORTS];
    port_st_t         rd_data_reg;
    logic [PORTS-1:0] vld_reg;

    port_st_t         byp_data_reg;
    logic [IDX_W-1:0] byp_addr_reg;
    logic             byp_valid_reg;

    port_st_t         st_cur;
    port_st_t         st_next;
    res_t             step_res;
    logic             wr_en;

    logic             m_valid_reg;
    res_t             res_reg;

    assign s1_adv     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_adv;
    assign s_fire     = s_valid && s_ready;
    assign s_in_range = ({30'd0, s_port} < 32'(PORTS));
    assign rd_addr    = IDX_W'(s_port);

    // request stage: capture sample and start the state read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_in_range_reg <= s_in_range;
            s1_addr_reg     <= rd_addr;
            s1_pins_reg     <= '{up: s_pin_up, dn: s_pin_down, lf: s_pin_left,
                                 rt: s_pin_right, tl: s_pin_tl, th: s_pin_th,
                                 tr: s_pin_tr};
        end
    end

    // state memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (s_fire && s_in_range) begin
            rd_data_reg <= state_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            state_mem[s1_addr_reg] <= st_next;
        end
    end

    // written flags, entries not yet written read as reset state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // bypass of the most recent write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (wr_en) begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byp_data_reg <= st_next;
            byp_addr_reg <= s1_addr_reg;
        end
    end

    // select current state of the port
    always_comb begin
        if (!s1_in_range_reg) begin
            st_cur = PORT_ST_RST;
        end else if (byp_valid_reg && (byp_addr_reg == s1_addr_reg)) begin
            st_cur = byp_data_reg;
        end else if (vld_reg[s1_addr_reg]) begin
            st_cur = rd_data_reg;
        end else begin
            st_cur = PORT_ST_RST;
        end
    end

    gpqd_step u_step (
        .alt_mode  (alt_mode_reg),
        .delta_tbl (delta_tbl_reg),
        .step_mult (step_mult_reg),
        .pins      (s1_pins_reg),
        .st_cur    (st_cur),
        .st_next   (st_next),
        .res       (step_res)
    );

    assign wr_en = s1_adv && s1_in_range_reg;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            res_reg <= s1_in_range_reg ? step_res : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_updated         = res_reg.updated;
    assign m_driving         = res_reg.driving;
    assign m_pad_up          = res_reg.pad_up;
    assign m_pad_down        = res_reg.pad_down;
    assign m_pad_left        = res_reg.pad_left;
    assign m_pad_right       = res_reg.pad_right;
    assign m_button_a        = res_reg.button_a;
    assign m_button_b        = res_reg.button_b;
    assign m_button_select   = res_reg.button_select;
    assign m_button_start    = res_reg.button_start;
    assign m_paddle_position = res_reg.paddle_position;
    assign m_axis_x          = res_reg.axis_x;

endmodule

`default_nettype wire

// ===== rtl/gpqd_checker.sv =====
`default_nettype none

module gpqd_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gpqd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gpqd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic [1:0]                      s_port,
    input  wire logic                            s_pin_up,
    input  wire logic                            s_pin_down,
    input  wire logic                            s_pin_left,
    input  wire logic                            s_pin_right,
    input  wire logic                            s_pin_tl,
    input  wire logic                            s_pin_th,
    input  wire logic                            s_pin_tr,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic                            m_updated,
    input  wire logic                            m_driving,
    input  wire logic                            m_pad_up,
    input  wire logic                            m_pad_down,
    input  wire logic                            m_pad_left,
    input  wire logic                            m_pad_right,
    input  wire logic                            m_button_a,
    input  wire logic                            m_button_b,
    input  wire logic                            m_button_select,
    input  wire logic                            m_button_start,
    input  wire logic [7:0]                      m_paddle_position,
    input  wire logic signed [15:0]              m_axis_x
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result stays valid and holds its axis, position and update flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_axis_x)
                                && $stable(m_paddle_position) && $stable(m_updated))
        else $error("stalled result changed");

    // axis follows position while driving
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_driving |->
            m_axis_x == $signed({~m_paddle_position[7], m_paddle_position[6:0], 8'h00}))
        else $error("axis does not match position");

    // axis is zero outside driving mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_driving |-> m_axis_x == 16'sd0)
        else $error("axis nonzero outside driving mode");

    // driving mode hides up/down and the combos
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_driving |->
            !m_pad_up && !m_pad_down && !m_button_select && !m_button_start)
        else $error("driving result shows up/down or combo");

endmodule

bind gamepad_paddle_quadrature_decoder_unit gpqd_checker u_gpqd_checker (.*);

`default_nettype wire

// ===== tb/tb_gamepad_paddle_quadrature_decoder_unit.sv =====
`timescale 1ns / 1ps

// one accepted pin sample
typedef struct packed {
    logic [1:0]       port;
    gpqd_pkg::pins_t  pins;
} pin_req_t;

// per-port paddle state and the frames it predicts
class frame_scoreboard;
    localparam int NPORTS = gpqd_pkg::PORTS_DEFAULT;

    logic              alt_mode;
    logic [31:0]       delta_tbl;
    logic [6:0]        step_mult;
    logic              drv [NPORTS];
    logic [1:0]        quad [NPORTS];
    logic [6:0]        last_pat [NPORTS];
    logic [7:0]        pos [NPORTS];
    gpqd_pkg::res_t    expected_frames [$];
    int                errors;
    int                n_samples;
    int                n_driving;
    int                n_combo;

    function new();
        alt_mode  = gpqd_pkg::ALT_MODE_RST;
        delta_tbl = gpqd_pkg::DELTA_TBL_RST;
        step_mult = gpqd_pkg::STEP_MULT_RST;
        for (int i = 0; i < NPORTS; i++) begin
            drv[i]      = gpqd_pkg::PORT_ST_RST.drv;
            quad[i]     = gpqd_pkg::PORT_ST_RST.quad;
            last_pat[i] = gpqd_pkg::PORT_ST_RST.pin;
            pos[i]      = gpqd_pkg::PORT_ST_RST.pos;
        end
        errors    = 0;
        n_samples = 0;
        n_driving = 0;
        n_combo   = 0;
    endfunction

    function void set_config(logic alt, logic [31:0] tbl, logic [6:0] mult);
        alt_mode  = alt;
        delta_tbl = tbl;
        step_mult = mult;
    endfunction

    function int pending();
        return expected_frames.size();
    endfunction

    // advance the port state for one request and queue the frame it yields
    function void note_sample(pin_req_t r);
        gpqd_pkg::res_t   e;
        gpqd_pkg::pins_t  p;
        logic [1:0]       cur;
        logic [1:0]       prv;
        logic signed [1:0] dlt;
        logic [6:0]       pat;
        logic             sec;
        logic             act;
        logic             sel;
        logic             run;
        int               idx;
        int               np;
        int               ax;
        p   = r.pins;
        e   = '0;
        act = 1'b0;
        sec = alt_mode ? p.th : p.tr;
        cur = {p.up, p.dn};
        prv = quad[r.port];

        // both lines low starts driving
        if (!alt_mode && !drv[r.port] && !p.up && !p.dn) begin
            drv[r.port] = 1'b1;
            act = 1'b1;
        end
        // quadrature step, may also start driving when code 0 is involved
        if (!alt_mode && cur != prv) begin
            idx = int'({prv, cur});
            dlt = delta_tbl[2*idx +: 2];
            if (!drv[r.port] && (cur == 2'd0 || prv == 2'd0) && dlt != 0) begin
                drv[r.port] = 1'b1;
                act = 1'b1;
            end
            if (drv[r.port] && dlt != 0) begin
                np = int'(pos[r.port]) + int'(dlt) * int'(step_mult);
                if (np < 0)
                    np = 0;
                if (np > int'(gpqd_pkg::POS_MAX))
                    np = int'(gpqd_pkg::POS_MAX);
                pos[r.port] = np[7:0];
            end
        end
        quad[r.port] = cur;

        // change detection on the reported pattern
        pat = {1'b1, sec, p.tl, p.rt, p.lf, p.dn, p.up};
        sel = alt_mode && ((pat & gpqd_pkg::COMBO_SEL_MASK) == '0);
        run = alt_mode && ((pat & gpqd_pkg::COMBO_START_MASK) == '0);
        e.updated = (pat != last_pat[r.port]) || act;
        if (e.updated)
            last_pat[r.port] = pat;

        // button mapping
        e.pad_up    = ~p.up;
        e.pad_down  = ~p.dn;
        e.pad_left  = ~p.lf;
        e.pad_right = ~p.rt;
        if (drv[r.port]) begin
            e.pad_up   = 1'b0;
            e.pad_down = 1'b0;
            e.button_a = ~p.tl;
            e.button_b = ~sec;
            ax = int'(pos[r.port]) * 256 - int'(gpqd_pkg::AXIS_BIAS);
            e.axis_x = ax[15:0];
            n_driving++;
        end else if (alt_mode) begin
            e.button_a = ~p.th;
            e.button_b = ~p.tl;
            if (sel) begin
                e.pad_up        = 1'b0;
                e.pad_down      = 1'b0;
                e.button_select = 1'b1;
            end
            if (run) begin
                e.pad_left     = 1'b0;
                e.pad_right    = 1'b0;
                e.button_start = 1'b1;
            end
            if (sel || run)
                n_combo++;
        end else begin
            e.button_a = ~p.tl;
            e.button_b = ~p.tr;
        end
        e.driving         = drv[r.port];
        e.paddle_position = pos[r.port];
        expected_frames.push_back(e);
        n_samples++;
    endfunction

    function void cmp(string field, int want, int seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            errors++;
        end
    endfunction

    // compare one frame from the block with the oldest prediction
    function void check_frame(gpqd_pkg::res_t got);
        gpqd_pkg::res_t want;
        if (expected_frames.size() == 0) begin
            $error("frame returned with no request outstanding");
            errors++;
            return;
        end
        want = expected_frames.pop_front();
        cmp("updated", want.updated, got.updated);
        cmp("driving", want.driving, got.driving);
        cmp("pad_up", want.pad_up, got.pad_up);
        cmp("pad_down", want.pad_down, got.pad_down);
        cmp("pad_left", want.pad_left, got.pad_left);
        cmp("pad_right", want.pad_right, got.pad_right);
        cmp("button_a", want.button_a, got.button_a);
        cmp("button_b", want.button_b, got.button_b);
        cmp("button_select", want.button_select, got.button_select);
        cmp("button_start", want.button_start, got.button_start);
        cmp("paddle_position", want.paddle_position, got.paddle_position);
        cmp("axis_x", int'($signed(want.axis_x)), int'($signed(got.axis_x)));
    endfunction
endclass

module tb_gamepad_paddle_quadrature_decoder_unit;
    import gpqd_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [31:0] QUAD_STEPS  = 32'h1EC963B4;  // +1 forward, -1 back, -2 skip
    localparam logic [6:0]  RELEASED    = 7'b1111111;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_port;
    logic                  s_pin_up;
    logic                  s_pin_down;
    logic                  s_pin_left;
    logic                  s_pin_right;
    logic                  s_pin_tl;
    logic                  s_pin_th;
    logic                  s_pin_tr;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_updated;
    logic                  m_driving;
    logic                  m_pad_up;
    logic                  m_pad_down;
    logic                  m_pad_left;
    logic                  m_pad_right;
    logic                  m_button_a;
    logic                  m_button_b;
    logic                  m_button_select;
    logic                  m_button_start;
    logic [7:0]            m_paddle_position;
    logic signed [15:0]    m_axis_x;

    frame_scoreboard board;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    n_settings = 0;
    logic [1:0]            walk [4];

    gamepad_paddle_quadrature_decoder_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_port            (s_port),
        .s_pin_up          (s_pin_up),
        .s_pin_down        (s_pin_down),
        .s_pin_left        (s_pin_left),
        .s_pin_right       (s_pin_right),
        .s_pin_tl          (s_pin_tl),
        .s_pin_th          (s_pin_th),
        .s_pin_tr          (s_pin_tr),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_updated         (m_updated),
        .m_driving         (m_driving),
        .m_pad_up          (m_pad_up),
        .m_pad_down        (m_pad_down),
        .m_pad_left        (m_pad_left),
        .m_pad_right       (m_pad_right),
        .m_button_a        (m_button_a),
        .m_button_b        (m_button_b),
        .m_button_select   (m_button_select),
        .m_button_start    (m_button_start),
        .m_paddle_position (m_paddle_position),
        .m_axis_x          (m_axis_x)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure, pattern chosen by cycle_count[8:6]
    always @(posedge aclk) begin
        case (cycle_count[8:6])
            3'd1: m_ready <= 1'($urandom_range(0, 1));
            3'd2: m_ready <= (cycle_count[1:0] == 2'd0);
            3'd3: m_ready <= ($urandom_range(0, 3) != 0);
            3'd5: m_ready <= cycle_count[4];
            3'd6: m_ready <= ($urandom_range(0, 2) == 0);
            default: m_ready <= 1'b1;
        endcase
    end

    // handshake monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_sample({s_port, s_pin_up, s_pin_down, s_pin_left, s_pin_right,
                                   s_pin_tl, s_pin_th, s_pin_tr});
            if (m_valid && m_ready)
                board.check_frame({m_updated, m_driving, m_pad_up, m_pad_down, m_pad_left,
                                   m_pad_right, m_button_a, m_button_b, m_button_select,
                                   m_button_start, m_paddle_position, m_axis_x});
        end
    end

    // present one request and hold it until taken, then maybe pause
    task automatic send_sample(input logic [1:0] port, input pins_t p);
        int gap;
        s_valid     <= 1'b1;
        s_port      <= port;
        s_pin_up    <= p.up;
        s_pin_down  <= p.dn;
        s_pin_left  <= p.lf;
        s_pin_right <= p.rt;
        s_pin_tl    <= p.tl;
        s_pin_th    <= p.th;
        s_pin_tr    <= p.tr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // wait until every predicted frame has come back
    task automatic drain_frames();
        s_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // program all three registers while idle
    task automatic write_config(input logic alt, input logic [31:0] tbl,
                                input logic [6:0] mult);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ALT_MODE;
        cfg_wdata <= {31'd0, alt};
        @(posedge aclk);
        cfg_index <= CFG_DELTA_TBL;
        cfg_wdata <= tbl;
        @(posedge aclk);
        cfg_index <= CFG_STEP_MULT;
        cfg_wdata <= {25'd0, mult};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_config(alt, tbl, mult);
        n_settings++;
    endtask

    // mostly quadrature walks per port with random buttons, some pure noise;
    // keep_idle steers clear of port 1 and of both lines low
    task automatic run_random(input int count, input bit keep_idle);
        logic [1:0] port;
        logic [1:0] code;
        logic [6:0] bits;
        pins_t      p;
        for (int k = 0; k < count; k++) begin
            bits = 7'($urandom_range(0, 127));
            p = bits;
            do
                port = 2'($urandom_range(0, 3));
            while (keep_idle && port == 2'd1);
            if ($urandom_range(0, 9) < 8) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: walk[port] = walk[port] + 2'd1;
                    8, 9, 10, 11, 12:       walk[port] = walk[port] - 2'd1;
                    13, 14:                 walk[port] = walk[port] + 2'd2;
                    default: ;
                endcase
                code = walk[port] ^ (walk[port] >> 1);
                p.up = code[1];
                p.dn = code[0];
            end
            if (keep_idle && !p.up && !p.dn)
                p.up = 1'b1;
            send_sample(port, p);
        end
    endtask

    initial begin
        board = new();
        for (int i = 0; i < 4; i++)
            walk[i] = 2'd2;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_ALT_MODE;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_port      <= 2'd0;
        s_pin_up    <= 1'b1;
        s_pin_down  <= 1'b1;
        s_pin_left  <= 1'b1;
        s_pin_right <= 1'b1;
        s_pin_tl    <= 1'b1;
        s_pin_th    <= 1'b1;
        s_pin_tr    <= 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // alternate wiring: combos, th as A, no driving
        write_config(1'b1, $urandom, 7'd5);
        send_sample(2'd0, RELEASED);
        send_sample(2'd0, RELEASED);        // same pattern, no update
        send_sample(2'd0, 7'b0000000);      // both combos at once
        send_sample(2'd1, 7'b0011111);      // select
        send_sample(2'd2, 7'b1100111);      // start
        send_sample(2'd3, 7'b1111101);      // th alone
        send_sample(2'd3, 7'b1111011);      // tl alone
        send_sample(2'd3, 7'b0111110);      // tr ignored here
        run_random(220, 1'b0);
        send_sample(2'd1, 7'b0011111);      // leave port 1 parked on code 0
        drain_frames();

        // normal wiring, flat table: plain pad mapping
        write_config(1'b0, 32'd0, 7'd1);
        send_sample(2'd0, RELEASED);
        send_sample(2'd0, 7'b1110000);
        send_sample(2'd2, 7'b0101100);
        send_sample(2'd3, 7'b1011111);      // code change with zero step
        run_random(200, 1'b1);
        drain_frames();

        // real quadrature table, unit speed
        write_config(1'b0, QUAD_STEPS, 7'd1);
        send_sample(2'd1, 7'b0111111);      // step away from code 0 enters driving
        send_sample(2'd1, RELEASED);
        send_sample(2'd0, 7'b0011111);      // both low enters driving
        send_sample(2'd2, 7'b0001111);
        run_random(200, 1'b0);
        drain_frames();

        // top speed: saturation at both ends
        write_config(1'b0, QUAD_STEPS, 7'd127);
        send_sample(2'd1, 7'b1011111);
        send_sample(2'd1, 7'b0011111);
        send_sample(2'd1, 7'b0111111);
        send_sample(2'd1, RELEASED);
        send_sample(2'd1, 7'b0111111);
        send_sample(2'd1, 7'b0011111);
        run_random(180, 1'b0);
        drain_frames();

        // zero speed, every step +1
        write_config(1'b0, 32'h55555555, 7'd0);
        run_random(120, 1'b0);
        drain_frames();

        // alternate wiring with driving ports: no movement
        write_config(1'b1, QUAD_STEPS, 7'd127);
        run_random(120, 1'b0);
        drain_frames();

        // every step -2, then random tables and speeds
        write_config(1'b0, 32'hAAAAAAAA, 7'd3);
        run_random(100, 1'b0);
        drain_frames();
        write_config(1'b0, $urandom, 7'($urandom_range(0, 127)));
        run_random(100, 1'b0);
        drain_frames();

        $display("checked %0d pin samples over %0d register settings",
                 board.n_samples, n_settings);
        $display("%0d frames in driving mode, %0d with a select or start combo",
                 board.n_driving, board.n_combo);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
